/* src/qkld_pkg.sv */
// Shared types and constants for the quadrature knob LED dimmer.
// Word structs, register map codes, reset values and the encoder
// transition decode. No dependencies.
package qkld_pkg;

    // Duty and PWM widths
    localparam int DUTY_BITS  = 16;
    localparam int STEP_BITS  = 16;
    localparam int HOLD_BITS  = 8;

    // Register map
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [1:0] {
        REG_FULL_SCALE     = 2'd0,
        REG_STEP_SIZE      = 2'd1,
        REG_DEBOUNCE_TICKS = 2'd2,
        REG_NONE           = 2'd3
    } reg_index_t;

    // Reset values
    localparam logic [DUTY_BITS-1:0] FULL_SCALE_RESET = 16'd65535;
    localparam logic [STEP_BITS-1:0] STEP_SIZE_RESET  = 16'd655;
    localparam logic [HOLD_BITS-1:0] DEBOUNCE_RESET   = 8'd30;
    localparam logic [DUTY_BITS-1:0] DUTY_RESET       = {1'b0, {(DUTY_BITS-1){1'b1}}};

    // Input and output words
    typedef struct packed {
        logic enc_a;
        logic enc_b;
        logic button_level;
    } in_word_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] compare_value;
        logic                 led_on;
        logic [DUTY_BITS-1:0] duty_level;
    } out_word_t;

    // Configuration seen by the core
    typedef struct packed {
        logic [DUTY_BITS-1:0] full_scale;
        logic [STEP_BITS-1:0] step_size;
        logic [HOLD_BITS-1:0] debounce_ticks;
    } cfg_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Decode previous and current AB phase into a turn direction.
    // A simultaneous jump of both channels or no change gives no turn.
    function automatic dir_t turn_dir(input logic [1:0] prev_phase, input logic [1:0] phase);
        dir_t dir;
        dir = DIR_NONE;
        case ({prev_phase, phase})
            4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = DIR_UP;
            4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = DIR_DOWN;
            default: dir = DIR_NONE;
        endcase
        return dir;
    endfunction

endpackage

/* src/quadrature_knob_led_dimmer.sv */
// Top level of the quadrature knob LED dimmer: APB register file,
// input handshake and a two-word output buffer around qkld_core.
// Depends on qkld_pkg and qkld_core.
//
//  channel | signals                              | word
//  --------+--------------------------------------+----------------------
//  input   | in_valid, in_stall, in_data          | qkld_pkg::in_word_t
//  output  | out_valid, out_stall, out_data       | qkld_pkg::out_word_t
//  config  | psel, penable, pwrite, paddr, pwdata | 32-bit registers
//
// One word per clock unless stalled: the core computes the new state and
// result in the cycle a word is accepted; it is registered in the output
// register, or in the skid entry if held. The two-entry buffer absorbs a
// stall, so in_stall rises only when both entries are full. Reset restores
// every register and the tick state to its default and empties the buffer.
module quadrature_knob_led_dimmer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  qkld_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output qkld_pkg::out_word_t                 out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qkld_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [qkld_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [qkld_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    qkld_pkg::cfg_t       cfg_reg;
    qkld_pkg::reg_index_t reg_sel;
    logic                 cfg_write;
    logic                 in_accept;
    logic                 out_take;
    qkld_pkg::out_word_t  result;
    qkld_pkg::out_word_t  out_word_reg;
    qkld_pkg::out_word_t  skid_word_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;

    // Register decode
    assign pready    = 1'b1;
    assign reg_sel   = qkld_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            qkld_pkg::REG_FULL_SCALE:
                prdata = {{(qkld_pkg::CFG_DATA_BITS-qkld_pkg::DUTY_BITS){1'b0}},
                          cfg_reg.full_scale};
            qkld_pkg::REG_STEP_SIZE:
                prdata = {{(qkld_pkg::CFG_DATA_BITS-qkld_pkg::STEP_BITS){1'b0}},
                          cfg_reg.step_size};
            qkld_pkg::REG_DEBOUNCE_TICKS:
                prdata = {{(qkld_pkg::CFG_DATA_BITS-qkld_pkg::HOLD_BITS){1'b0}},
                          cfg_reg.debounce_ticks};
            default: prdata = '0;
        endcase
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale     <= qkld_pkg::FULL_SCALE_RESET;
            cfg_reg.step_size      <= qkld_pkg::STEP_SIZE_RESET;
            cfg_reg.debounce_ticks <= qkld_pkg::DEBOUNCE_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                qkld_pkg::REG_FULL_SCALE:
                    cfg_reg.full_scale <= pwdata[qkld_pkg::DUTY_BITS-1:0];
                qkld_pkg::REG_STEP_SIZE:
                    cfg_reg.step_size <= pwdata[qkld_pkg::STEP_BITS-1:0];
                qkld_pkg::REG_DEBOUNCE_TICKS:
                    cfg_reg.debounce_ticks <= pwdata[qkld_pkg::HOLD_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    qkld_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .item   (in_data),
        .cfg    (cfg_reg),
        .result (result)
    );

    // Output buffer: fill the output register first, spill to the skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload moves, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
                out_word_reg <= skid_word_reg;
        end
        else if (in_accept)
        begin
            if (out_valid_reg && !out_take)
                skid_word_reg <= result;
            else
                out_word_reg <= result;
        end
    end

endmodule

/* src/qkld_core.sv */
// Tick state and next-state logic: encoder decode, duty update,
// button debounce, enable toggle and compare value.
// Depends on qkld_pkg.
module qkld_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  qkld_pkg::in_word_t item,
    input  qkld_pkg::cfg_t     cfg,
    output qkld_pkg::out_word_t result
);

    logic [1:0]                     prev_phase_reg;
    logic [1:0]                     prev_phase_next;
    logic                           raw_prev_reg;
    logic                           raw_prev_next;
    logic                           button_stable_reg;
    logic                           button_stable_next;
    logic [qkld_pkg::HOLD_BITS-1:0] hold_count_reg;
    logic [qkld_pkg::HOLD_BITS-1:0] hold_count_next;
    logic                           enabled_reg;
    logic                           enabled_next;
    logic [qkld_pkg::DUTY_BITS-1:0] duty_reg;
    logic [qkld_pkg::DUTY_BITS-1:0] duty_next;

    // Encoder: move duty with the enable from before this tick
    always_comb
    begin
        logic [1:0]                   phase;
        qkld_pkg::dir_t               dir;
        logic [qkld_pkg::DUTY_BITS:0] sum;
        phase           = {item.enc_a, item.enc_b};
        dir             = qkld_pkg::turn_dir(prev_phase_reg, phase);
        sum             = {1'b0, duty_reg} + {1'b0, cfg.step_size};
        prev_phase_next = phase;
        duty_next       = duty_reg;
        if (enabled_reg && (cfg.step_size != '0))
        begin
            case (dir)
                qkld_pkg::DIR_UP:
                begin
                    if (sum >= {1'b0, cfg.full_scale})
                        duty_next = cfg.full_scale;
                    else
                        duty_next = sum[qkld_pkg::DUTY_BITS-1:0];
                end
                qkld_pkg::DIR_DOWN:
                begin
                    if (duty_reg <= cfg.step_size)
                        duty_next = '0;
                    else
                        duty_next = duty_reg - cfg.step_size;
                end
                default: duty_next = duty_reg;
            endcase
        end
    end

    // Button: count equal samples, toggle enable on a debounced press
    always_comb
    begin
        raw_prev_next      = raw_prev_reg;
        hold_count_next    = hold_count_reg;
        button_stable_next = button_stable_reg;
        enabled_next       = enabled_reg;
        if (item.button_level != raw_prev_reg)
        begin
            hold_count_next = '0;
            raw_prev_next   = item.button_level;
        end
        else if (hold_count_reg < cfg.debounce_ticks)
        begin
            hold_count_next = hold_count_reg + 1'b1;
        end
        else if (item.button_level != button_stable_reg)
        begin
            button_stable_next = item.button_level;
            if (!item.button_level)
                enabled_next = !enabled_reg;
        end
    end

    // Result: active-low compare, floored at zero
    always_comb
    begin
        result.led_on     = enabled_next;
        result.duty_level = duty_next;
        if (!enabled_next)
            result.compare_value = cfg.full_scale;
        else if (cfg.full_scale > duty_next)
            result.compare_value = cfg.full_scale - duty_next;
        else
            result.compare_value = '0;
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_phase_reg    <= '0;
            raw_prev_reg      <= 1'b1;
            button_stable_reg <= 1'b1;
            hold_count_reg    <= '0;
            enabled_reg       <= 1'b1;
            duty_reg          <= qkld_pkg::DUTY_RESET;
        end
        else if (accept)
        begin
            prev_phase_reg    <= prev_phase_next;
            raw_prev_reg      <= raw_prev_next;
            button_stable_reg <= button_stable_next;
            hold_count_reg    <= hold_count_next;
            enabled_reg       <= enabled_next;
            duty_reg          <= duty_next;
        end
    end

endmodule

/* test/qkld_dimmer_checker.sv */
// Watches the word channels and the register port of the LED dimmer,
// predicts each result word and compares it field by field.
// Depends on qkld_pkg.
module qkld_dimmer_checker
    import qkld_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  in_word_t                  in_data,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  out_word_t                 out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [CFG_ADDR_BITS-1:0]  paddr,
    input  logic [CFG_DATA_BITS-1:0]  pwdata,
    output int unsigned               fail_count,
    output int unsigned               pending
);

    // Shadow of the register file and the tick state
    cfg_t                 dim_cfg;
    logic [1:0]           last_phase;
    logic                 raw_last;
    logic                 btn_stable;
    logic [HOLD_BITS-1:0] hold_cnt;
    logic                 led_en;
    logic [DUTY_BITS-1:0] duty;

    out_word_t            expected_words[$];
    int unsigned          mismatch_count;

    // Direction from the Gray position difference of two AB phases
    function automatic dir_t knob_turn(input logic [1:0] from_ph, input logic [1:0] to_ph);
        logic [1:0] p0;
        logic [1:0] p1;
        logic [1:0] delta;
        p0 = {from_ph[1], from_ph[1] ^ from_ph[0]};
        p1 = {to_ph[1], to_ph[1] ^ to_ph[0]};
        delta = p1 - p0;
        if (delta == 2'd1)
            return DIR_DOWN;
        if (delta == 2'd3)
            return DIR_UP;
        return DIR_NONE;
    endfunction

    // Advance the dimmer by one tick and build the result word
    task automatic dimmer_tick(input in_word_t w, output out_word_t r);
        dir_t               dir;
        logic [DUTY_BITS:0] sum;
        logic               en_prev;
        en_prev = led_en;

        // encoder uses the enable from before this tick's button update
        dir = knob_turn(last_phase, {w.enc_a, w.enc_b});
        if (dir != DIR_NONE && en_prev && dim_cfg.step_size != '0)
        begin
            if (dir == DIR_UP)
            begin
                sum = {1'b0, duty} + {1'b0, dim_cfg.step_size};
                duty = (sum >= {1'b0, dim_cfg.full_scale}) ?
                       dim_cfg.full_scale : sum[DUTY_BITS-1:0];
            end
            else
            begin
                duty = (duty <= dim_cfg.step_size) ? '0 : duty - dim_cfg.step_size;
            end
        end
        last_phase = {w.enc_a, w.enc_b};

        // debounce: a level must repeat debounce_ticks + 1 more times
        if (w.button_level != raw_last)
        begin
            hold_cnt = '0;
            raw_last = w.button_level;
        end
        else if (hold_cnt < dim_cfg.debounce_ticks)
        begin
            hold_cnt = hold_cnt + 1'b1;
        end
        else if (w.button_level != btn_stable)
        begin
            btn_stable = w.button_level;
            if (!btn_stable)
                led_en = !led_en;
        end

        r.led_on = led_en;
        r.duty_level = duty;
        if (!led_en)
            r.compare_value = dim_cfg.full_scale;
        else
            r.compare_value = (dim_cfg.full_scale > duty) ? dim_cfg.full_scale - duty : '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        out_word_t got_w;
        if (!rst_n)
        begin
            dim_cfg.full_scale = FULL_SCALE_RESET;
            dim_cfg.step_size = STEP_SIZE_RESET;
            dim_cfg.debounce_ticks = DEBOUNCE_RESET;
            last_phase = 2'b00;
            raw_last = 1'b1;
            btn_stable = 1'b1;
            hold_cnt = '0;
            led_en = 1'b1;
            duty = DUTY_RESET;
            expected_words.delete();
        end
        else
        begin
            // check the result word against the oldest prediction
            if (out_valid && !out_stall)
            begin
                got_w = out_data;
                if (expected_words.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result word cmp=%0d led=%0b duty=%0d",
                                 $time, got_w.compare_value, got_w.led_on, got_w.duty_level);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (got_w.compare_value !== exp_w.compare_value ||
                        got_w.led_on !== exp_w.led_on ||
                        got_w.duty_level !== exp_w.duty_level)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch exp cmp=%0d led=%0b duty=%0d,",
                                      " got cmp=%0d led=%0b duty=%0d"},
                                     $time, exp_w.compare_value, exp_w.led_on,
                                     exp_w.duty_level, got_w.compare_value,
                                     got_w.led_on, got_w.duty_level);
                    end
                end
            end

            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_FULL_SCALE:     dim_cfg.full_scale = pwdata[DUTY_BITS-1:0];
                    REG_STEP_SIZE:      dim_cfg.step_size = pwdata[STEP_BITS-1:0];
                    REG_DEBOUNCE_TICKS: dim_cfg.debounce_ticks = pwdata[HOLD_BITS-1:0];
                    default: ;
                endcase
            end

            // predict the word accepted at this edge
            if (in_valid && !in_stall)
            begin
                dimmer_tick(in_data, exp_w);
                expected_words.push_back(exp_w);
            end
        end
        pending = expected_words.size();
        fail_count = mismatch_count;
    end

endmodule

/* test/quadrature_knob_led_dimmer_test.sv */
// Stimulus and verdict for the quadrature knob LED dimmer: drives encoder
// and button ticks and register writes, with qkld_dimmer_checker beside it.
// Depends on qkld_pkg, quadrature_knob_led_dimmer and qkld_dimmer_checker.
module quadrature_knob_led_dimmer_test;
    import qkld_pkg::*;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    in_word_t                  in_data = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    out_word_t                 out_data;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  paddr = '0;
    logic [CFG_DATA_BITS-1:0]  pwdata = '0;
    logic [CFG_DATA_BITS-1:0]  prdata;
    logic                      pready;
    int unsigned               fail_count;
    int unsigned               pending;

    // Pacing and knob/button stimulus state
    int                        idle_pct = 0;
    int                        stall_pct = 0;
    int unsigned               words_sent = 0;
    logic [1:0]                knob_pos = 2'd0;
    logic                      btn_level = 1'b1;
    int                        btn_left = 0;
    int                        cur_deb = 30;

    // Phase order that crosses every previous/current AB pair once
    localparam logic [1:0] PHASE_TOUR [16] = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                                               2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};

    quadrature_knob_led_dimmer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    qkld_dimmer_checker dimmer_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 clk = ~clk;

    // Hard stop for a hung run
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Random receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // AB levels of a Gray position
    function automatic logic [1:0] gray_phase(input logic [1:0] pos);
        return {pos[1], pos[1] ^ pos[0]};
    endfunction

    // Hand one word to the block and hold it until accepted
    task automatic send_word(input in_word_t w);
        if (words_sent < 333)
        begin
            idle_pct = 21;
            stall_pct = 67;
        end
        else if (words_sent < 666)
        begin
            idle_pct = 67;
            stall_pct = 21;
        end
        else
        begin
            idle_pct = 0;
            stall_pct = 0;
        end
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // One register write: setup then access
    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait for every predicted word to come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input int fs, input int step, input int deb);
        drain_results();
        write_reg(REG_FULL_SCALE, fs);
        write_reg(REG_STEP_SIZE, step);
        write_reg(REG_DEBOUNCE_TICKS, deb);
        write_reg(REG_NONE, $urandom);
        cur_deb = deb;
        btn_left = 0;
    endtask

    // Mostly legal knob motion and button runs, some jumps and glitches
    task automatic knob_word(output in_word_t w);
        int r;
        r = $urandom_range(99);
        if (r < 38)
            knob_pos = knob_pos + 2'd1;
        else if (r < 76)
            knob_pos = knob_pos - 2'd1;
        else if (r < 88)
            knob_pos = knob_pos;
        else if (r < 95)
            knob_pos = knob_pos + 2'd2;
        else
            knob_pos = 2'($urandom_range(3));
        {w.enc_a, w.enc_b} = gray_phase(knob_pos);

        if (btn_left == 0)
        begin
            btn_level = !btn_level;
            if ($urandom_range(3) != 0)
                btn_left = cur_deb + 1 + $urandom_range(3);
            else
                btn_left = $urandom_range(cur_deb + 1, 1);
        end
        btn_left--;
        w.button_level = btn_level;
    endtask

    task automatic run_phase(input int fs, input int step, input int deb, input int count);
        in_word_t w;
        configure(fs, step, deb);
        repeat (count)
        begin
            knob_word(w);
            send_word(w);
        end
    endtask

    initial
    begin
        in_word_t w;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: duty starts above full scale, huge step hits both rails
        configure(1000, 65535, 0);
        foreach (PHASE_TOUR[i])
        begin
            {w.enc_a, w.enc_b} = PHASE_TOUR[i];
            w.button_level = 1'b1;
            send_word(w);
        end
        knob_pos = 2'd0;
        for (int i = 0; i < 8; i++)
        begin
            // press, release, press, release with the knob turning every tick
            knob_pos = knob_pos + 2'd1;
            {w.enc_a, w.enc_b} = gray_phase(knob_pos);
            w.button_level = i[1];
            send_word(w);
        end

        // Random phases across register settings and extremes
        run_phase(65535, 655, 30, 250);
        run_phase(1, 1, 0, 100);
        run_phase(0, 300, 3, 100);
        run_phase(40000, 0, 255, 300);
        run_phase(65535, 65535, 1, 100);
        repeat (4)
            run_phase($urandom_range(65535, 1), $urandom_range(4000), $urandom_range(8), 40);

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
src/qkld_pkg.sv
src/qkld_core.sv
src/quadrature_knob_led_dimmer.sv
test/qkld_dimmer_checker.sv
test/quadrature_knob_led_dimmer_test.sv
